/* src/lwbpt_pkg.sv */
`default_nettype none

package lwbpt_pkg;

  // Fixed field widths of the access and result items.
  localparam int unsigned OFFSET_W   = 64;
  localparam int unsigned SLOT_OUT_W = 6;
  localparam int unsigned COUNT_W    = 32;

  // Commands from the controller to the datapath, one per phase.
  typedef struct packed {
    logic load;    // capture the accepted access
    logic lookup;  // register tag matches and victim candidate
    logic choose;  // register slot, aging limit and write-back
    logic commit;  // update the table and the result register
  } lwbpt_cmd_t;

endpackage

`default_nettype wire

/* src/lwbpt_chan_if.sv */
`default_nettype none

interface lwbpt_in_if import lwbpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] page_offset;
  logic                write_access;

  modport source (output valid, output page_offset, output write_access, input ready);
  modport sink   (input valid, input page_offset, input write_access, output ready);
endinterface

interface lwbpt_out_if import lwbpt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [SLOT_OUT_W-1:0] slot;
  logic                  writeback_valid;
  logic [OFFSET_W-1:0]   writeback_offset;
  logic [COUNT_W-1:0]    hits_total;
  logic [COUNT_W-1:0]    misses_total;

  modport source (output valid, output hit, output slot, output writeback_valid,
                  output writeback_offset, output hits_total, output misses_total,
                  input ready);
  modport sink   (input valid, input hit, input slot, input writeback_valid,
                  input writeback_offset, input hits_total, input misses_total,
                  output ready);
endinterface

`default_nettype wire

/* src/lwbpt_ctrl.sv */
`default_nettype none

module lwbpt_ctrl import lwbpt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  output lwbpt_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CHOOSE,
    ST_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.load   = in_valid && in_ready_r;
    cmd.lookup = (state_r == ST_LOOKUP);
    cmd.choose = (state_r == ST_CHOOSE);
    cmd.commit = (state_r == ST_COMMIT) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt    = ST_LOOKUP;
          in_ready_nxt = 1'b0;
        end
      end
      ST_LOOKUP: state_nxt = ST_CHOOSE;
      ST_CHOOSE: state_nxt = ST_COMMIT;
      ST_COMMIT: begin
        // Hold until the result register is free or drains this cycle.
        if (cmd.commit) begin
          state_nxt     = ST_IDLE;
          in_ready_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* src/lwbpt_datapath.sv */
`default_nettype none

module lwbpt_datapath import lwbpt_pkg::*; #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lwbpt_cmd_t            cmd,
  input  wire logic [OFFSET_W-1:0]   in_page_offset,
  input  wire logic                  in_write_access,
  output logic                       out_hit,
  output logic [SLOT_OUT_W-1:0]      out_slot,
  output logic                       out_writeback_valid,
  output logic [OFFSET_W-1:0]        out_writeback_offset,
  output logic [COUNT_W-1:0]         out_hits_total,
  output logic [COUNT_W-1:0]         out_misses_total
);

  localparam int unsigned SW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW    = $clog2(ENTRIES + 1);
  localparam int unsigned EXT_W = (SW > SLOT_OUT_W) ? SW : SLOT_OUT_W;

  // Table state: tags have no reset, they are compared only while valid.
  logic [OFFSET_W-1:0] tag_r [ENTRIES];
  logic [SW-1:0]       rank_r [ENTRIES];
  logic [ENTRIES-1:0]  valid_r;
  logic [ENTRIES-1:0]  dirty_r;
  logic [CW-1:0]       occ_r;
  logic [COUNT_W-1:0]  hit_cnt_r;
  logic [COUNT_W-1:0]  miss_cnt_r;

  // Access capture and phase registers.
  logic [OFFSET_W-1:0] key_r;
  logic                wr_r;
  logic [ENTRIES-1:0]  match_r;
  logic [ENTRIES-1:0]  vict_r;
  logic                hit_r;
  logic                full_r;
  logic [SW-1:0]       slot_r;
  logic [CW-1:0]       limit_r;
  logic                wb_valid_r;
  logic [OFFSET_W-1:0] wb_off_r;

  // Result register.
  logic                  res_hit_r;
  logic [SLOT_OUT_W-1:0] res_slot_r;
  logic                  res_wb_valid_r;
  logic [OFFSET_W-1:0]   res_wb_off_r;
  logic [COUNT_W-1:0]    res_hits_r;
  logic [COUNT_W-1:0]    res_misses_r;

  // Lookup: parallel compare, and the entry holding the oldest rank.
  logic [ENTRIES-1:0] match_nxt;
  logic [ENTRIES-1:0] vict_nxt;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_nxt[i] = valid_r[i] && (tag_r[i] == key_r);
      vict_nxt[i]  = valid_r[i] && (rank_r[i] == SW'(ENTRIES - 1));
    end
  end

  // Choose: encode one-hot vectors and pick up rank, tag and dirty.
  logic [SW-1:0]       hit_idx;
  logic [SW-1:0]       hit_rank;
  logic [SW-1:0]       vict_idx;
  logic [OFFSET_W-1:0] vict_tag;
  logic                vict_dirty;
  logic                full;
  logic [SW-1:0]       slot_nxt;
  logic [CW-1:0]       limit_nxt;
  logic                wb_valid_nxt;
  logic [OFFSET_W-1:0] wb_off_nxt;

  always_comb begin
    hit_idx    = '0;
    hit_rank   = '0;
    vict_idx   = '0;
    vict_tag   = '0;
    vict_dirty = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_r[i]) begin
        hit_idx  = hit_idx | SW'(i);
        hit_rank = hit_rank | rank_r[i];
      end
      if (vict_r[i]) begin
        vict_idx   = vict_idx | SW'(i);
        vict_tag   = vict_tag | tag_r[i];
        vict_dirty = vict_dirty | dirty_r[i];
      end
    end
    full         = (occ_r == CW'(ENTRIES));
    wb_valid_nxt = 1'b0;
    wb_off_nxt   = '0;
    if (|match_r) begin
      slot_nxt  = hit_idx;
      limit_nxt = CW'(hit_rank);
    end else if (!full) begin
      // Slots fill in order and never empty, so the free slot is the count.
      slot_nxt  = occ_r[SW-1:0];
      limit_nxt = occ_r;
    end else begin
      slot_nxt     = vict_idx;
      limit_nxt    = CW'(ENTRIES - 1);
      wb_valid_nxt = vict_dirty;
      wb_off_nxt   = vict_dirty ? vict_tag : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_page_offset;
      wr_r  <= in_write_access;
    end
    if (cmd.lookup) begin
      match_r <= match_nxt;
      vict_r  <= vict_nxt;
    end
    if (cmd.choose) begin
      hit_r      <= |match_r;
      full_r     <= full;
      slot_r     <= slot_nxt;
      limit_r    <= limit_nxt;
      wb_valid_r <= wb_valid_nxt;
      wb_off_r   <= wb_off_nxt;
    end
  end

  // Commit: age, install or touch, count, and fill the result register.
  logic [COUNT_W-1:0] hit_cnt_nxt;
  logic [COUNT_W-1:0] miss_cnt_nxt;
  logic [EXT_W-1:0]   slot_ext;

  always_comb begin
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (hit_r) begin
      if (hit_cnt_r != '1) hit_cnt_nxt = hit_cnt_r + 1'b1;
    end else begin
      if (miss_cnt_r != '1) miss_cnt_nxt = miss_cnt_r + 1'b1;
    end
    slot_ext = EXT_W'(slot_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_r == SW'(i)) begin
          if (!hit_r) tag_r[i] <= key_r;
        end
      end
      res_hit_r      <= hit_r;
      res_slot_r     <= slot_ext[SLOT_OUT_W-1:0];
      res_wb_valid_r <= wb_valid_r;
      res_wb_off_r   <= wb_off_r;
      res_hits_r     <= hit_cnt_nxt;
      res_misses_r   <= miss_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      dirty_r    <= '0;
      occ_r      <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_r == SW'(i)) begin
          rank_r[i]  <= '0;
          valid_r[i] <= 1'b1;
          dirty_r[i] <= hit_r ? (dirty_r[i] | wr_r) : wr_r;
        end else if (valid_r[i] && (CW'(rank_r[i]) < limit_r)) begin
          rank_r[i] <= rank_r[i] + 1'b1;
        end
      end
      if (!hit_r && !full_r) occ_r <= occ_r + 1'b1;
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
    end
  end

  assign out_hit              = res_hit_r;
  assign out_slot             = res_slot_r;
  assign out_writeback_valid  = res_wb_valid_r;
  assign out_writeback_offset = res_wb_off_r;
  assign out_hits_total       = res_hits_r;
  assign out_misses_total     = res_misses_r;

endmodule

`default_nettype wire

/* src/lru_write_back_page_tags.sv */
`default_nettype none

// Channel   Dir  Handshake       Payload
// in_ch     in   valid / ready   page_offset[63:0], write_access
// out_ch    out  valid / ready   hit, slot[5:0], writeback_valid, writeback_offset[63:0],
//                                hits_total[31:0], misses_total[31:0]
//
// Each access runs through its phases: capture at the transfer, tag compare,
// slot and victim selection, table update; in_ch.ready stays low from capture to update.
// The result is valid after the update; the next access may transfer meanwhile, and
// the update stalls only while the previous result is still waiting on out_ch.
// Reset (rst_n low, synchronous) clears valid, dirty, ranks, fill count and both
// counters at once; tags hold no reset value and are only compared while valid.
module lru_write_back_page_tags import lwbpt_pkg::*; #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lwbpt_in_if.sink    in_ch,
  lwbpt_out_if.source out_ch
);

  lwbpt_cmd_t cmd;

  // Controller: sequences each access through its phases and owns the handshakes.
  lwbpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Datapath: tag table, recency ranks, counters and the result register.
  lwbpt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_page_offset       (in_ch.page_offset),
    .in_write_access      (in_ch.write_access),
    .out_hit              (out_ch.hit),
    .out_slot             (out_ch.slot),
    .out_writeback_valid  (out_ch.writeback_valid),
    .out_writeback_offset (out_ch.writeback_offset),
    .out_hits_total       (out_ch.hits_total),
    .out_misses_total     (out_ch.misses_total)
  );

endmodule

`default_nettype wire
